### hdl/positional_circular_list_macros.svh
// Assertion macros shared by the list block.
`ifndef POSITIONAL_CIRCULAR_LIST_MACROS_SVH
`define POSITIONAL_CIRCULAR_LIST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list assertion failed");

// Next-cycle implication, checked out of reset.
`define PCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list assertion failed");

`endif

### hdl/pcl_pkg.sv
// Types, constants and codes of the positional circular list.
`default_nettype none
package pcl_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LEN_W  = 5;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    ACT_PREPEND  = 3'd0,
    ACT_APPEND   = 3'd1,
    ACT_INSERT   = 3'd2,
    ACT_DELETE   = 3'd3,
    ACT_DEL_HEAD = 3'd4,
    ACT_DEL_TAIL = 3'd5,
    ACT_READ     = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_RESERVED = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_FULL     = 3'd4
  } stat_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_INSERT = 2'd1,
    CH_DELETE = 2'd2,
    CH_ROTATE = 2'd3
  } chain_mode_t;

  typedef struct packed {
    chain_mode_t              mode;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } chain_cmd_t;

  typedef struct packed {
    act_t                     action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pcl_in_t;

  typedef struct packed {
    stat_t                    status;
    logic signed [DATA_W-1:0] value_out;
    logic                     last;
    logic [LEN_W-1:0]         length;
  } pcl_out_t;

endpackage
`default_nettype wire

### hdl/pcl_cell.sv
// One storage cell of the list chain.
`default_nettype none
module pcl_cell (
  input  wire logic                                clk,
  input  wire pcl_pkg::chain_cmd_t                 cmd,
  input  wire logic [pcl_pkg::IDX_W-1:0]           cell_idx,
  input  wire logic signed [pcl_pkg::DATA_W-1:0]   left_val,
  input  wire logic signed [pcl_pkg::DATA_W-1:0]   right_val,
  output logic signed [pcl_pkg::DATA_W-1:0]        data_r
);

  logic signed [pcl_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.mode)
      pcl_pkg::CH_HOLD: begin
        data_nxt = data_r;
      end
      pcl_pkg::CH_INSERT: begin
        if (cell_idx > cmd.idx) begin
          data_nxt = left_val;
        end else if (cell_idx == cmd.idx) begin
          data_nxt = cmd.value;
        end
      end
      pcl_pkg::CH_DELETE: begin
        if (cell_idx >= cmd.idx) begin
          data_nxt = right_val;
        end
      end
      pcl_pkg::CH_ROTATE: begin
        data_nxt = right_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

### hdl/pcl_chain.sv
// Ring of list cells with neighbour wiring; cell zero is the head.
`default_nettype none
module pcl_chain (
  input  wire logic                              clk,
  input  wire pcl_pkg::chain_cmd_t               cmd,
  output logic signed [pcl_pkg::DATA_W-1:0]      head_val
);

  logic signed [pcl_pkg::DATA_W-1:0] cell_data [pcl_pkg::DEPTH];

  for (genvar g = 0; g < pcl_pkg::DEPTH; g++) begin : g_cell
    pcl_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cell_idx  (pcl_pkg::IDX_W'(g)),
      .left_val  (cell_data[(g + pcl_pkg::DEPTH - 1) % pcl_pkg::DEPTH]),
      .right_val (cell_data[(g + 1) % pcl_pkg::DEPTH]),
      .data_r    (cell_data[g])
    );
  end

  assign head_val = cell_data[0];

endmodule
`default_nettype wire

### hdl/positional_circular_list.sv
// Top level of the positional circular list: command decode, sequencer and result register.
// An edit command (prepend, append, insert at, delete at, delete first, delete last) shifts the
// cells from the edit point onward towards or away from it together (delete last only shrinks
// the count), and one beat with last set comes out on the next cycle. A read-out of a non-empty
// list keeps busy high while the ring rotates once past the head cell, giving one beat per
// stored element in list order, the final one with last set; a read-out of an empty list is a
// single beat. Beats appear on out_strobe for one cycle each and cannot be held off, so the
// receiver must take every beat as it comes.
`default_nettype none
`include "positional_circular_list_macros.svh"
module positional_circular_list (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pcl_pkg::pcl_in_t  in_item,
  output logic                   out_strobe,
  output pcl_pkg::pcl_out_t      out_item
);

  pcl_pkg::fsm_t                        state_r, state_nxt;
  logic [pcl_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [pcl_pkg::IDX_W-1:0]            rd_cnt_r, rd_cnt_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  pcl_pkg::pcl_out_t                    out_r, out_nxt;
  pcl_pkg::chain_cmd_t                  cmd;
  pcl_pkg::stat_t                       stat;
  logic signed [pcl_pkg::DATA_W-1:0]    head_val;
  logic [pcl_pkg::CMP_W-1:0]            pos_e, cnt_e;
  logic [pcl_pkg::POS_W-1:0]            pos_m1;
  logic                                 empty, full, pos_one;

  assign pos_e   = pcl_pkg::CMP_W'(in_item.position);
  assign cnt_e   = pcl_pkg::CMP_W'(cnt_r);
  assign pos_m1  = in_item.position - 1'b1;
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == pcl_pkg::CNT_W'(pcl_pkg::DEPTH));
  assign pos_one = (in_item.position == pcl_pkg::POS_W'(1));

  pcl_chain u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .head_val (head_val)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcl_pkg::S_IDLE: begin
        if (start && in_item.action == pcl_pkg::ACT_READ && !empty) begin
          state_nxt = pcl_pkg::S_READ;
        end
      end
      pcl_pkg::S_READ: begin
        if (rd_cnt_r == pcl_pkg::IDX_W'(pcl_pkg::DEPTH - 1)) begin
          state_nxt = pcl_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd           = '{mode: pcl_pkg::CH_HOLD, idx: '0, value: in_item.value};
    cnt_nxt       = cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    stat          = pcl_pkg::STAT_OK;
    unique case (state_r)
      pcl_pkg::S_IDLE: begin
        rd_cnt_nxt = '0;
        if (start) begin
          unique case (in_item.action)
            pcl_pkg::ACT_PREPEND: begin
              if (full) begin
                stat = pcl_pkg::STAT_FULL;
              end else begin
                cmd.mode = pcl_pkg::CH_INSERT;
                cmd.idx  = '0;
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            pcl_pkg::ACT_APPEND: begin
              if (full) begin
                stat = pcl_pkg::STAT_FULL;
              end else begin
                cmd.mode = pcl_pkg::CH_INSERT;
                cmd.idx  = pcl_pkg::IDX_W'(cnt_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            pcl_pkg::ACT_INSERT: begin
              if (pos_one) begin
                stat = pcl_pkg::STAT_RESERVED;
              end else if (empty) begin
                stat = pcl_pkg::STAT_EMPTY;
              end else if (pos_e < pcl_pkg::CMP_W'(2) || pos_e > cnt_e + 1'b1) begin
                stat = pcl_pkg::STAT_RANGE;
              end else if (full) begin
                stat = pcl_pkg::STAT_FULL;
              end else begin
                cmd.mode = pcl_pkg::CH_INSERT;
                cmd.idx  = pcl_pkg::IDX_W'(pos_m1);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            pcl_pkg::ACT_DELETE: begin
              if (pos_one) begin
                stat = pcl_pkg::STAT_RESERVED;
              end else if (empty) begin
                stat = pcl_pkg::STAT_EMPTY;
              end else if (pos_e < pcl_pkg::CMP_W'(2) || pos_e > cnt_e) begin
                stat = pcl_pkg::STAT_RANGE;
              end else begin
                cmd.mode = pcl_pkg::CH_DELETE;
                cmd.idx  = pcl_pkg::IDX_W'(pos_m1);
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            pcl_pkg::ACT_DEL_HEAD: begin
              if (empty) begin
                stat = pcl_pkg::STAT_EMPTY;
              end else begin
                cmd.mode = pcl_pkg::CH_DELETE;
                cmd.idx  = '0;
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            pcl_pkg::ACT_DEL_TAIL: begin
              if (empty) begin
                stat = pcl_pkg::STAT_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            pcl_pkg::ACT_READ: begin
              if (empty) begin
                stat = pcl_pkg::STAT_EMPTY;
              end
            end
            default: begin
              stat = pcl_pkg::STAT_OK;
            end
          endcase
          if (in_item.action != pcl_pkg::ACT_READ || empty) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{status: stat, value_out: '0, last: 1'b1,
                        length: pcl_pkg::LEN_W'(cnt_nxt)};
          end
        end
      end
      pcl_pkg::S_READ: begin
        cmd.mode   = pcl_pkg::CH_ROTATE;
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (pcl_pkg::CNT_W'(rd_cnt_r) < cnt_r) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: pcl_pkg::STAT_OK, value_out: head_val,
                      last: (pcl_pkg::CNT_W'(rd_cnt_r) + 1'b1 == cnt_r),
                      length: pcl_pkg::LEN_W'(cnt_r)};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcl_pkg::S_IDLE;
      cnt_r       <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy       = (state_r == pcl_pkg::S_READ);
  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  `PCL_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= pcl_pkg::CNT_W'(pcl_pkg::DEPTH))
  `PCL_ASSERT_NOW(a_mid_beat_in_read, out_valid_r && !out_r.last, state_r == pcl_pkg::S_READ)
  `PCL_ASSERT_NEXT(a_full_prepend,
      start && !busy && in_item.action == pcl_pkg::ACT_PREPEND && full,
      out_valid_r && out_r.status == pcl_pkg::STAT_FULL)

endmodule
`default_nettype wire
